FILE: hdl/prng_substitution_stream_cipher_top_assert.svh
// Assertion macros shared by the cipher RTL
`ifndef PRNG_SUBSTITUTION_STREAM_CIPHER_TOP_ASSERT_SVH
`define PRNG_SUBSTITUTION_STREAM_CIPHER_TOP_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define PLSC_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define PLSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define PLSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/plsc_pkg.sv
// Shared types, codes and constants of the substitution stream cipher
package plsc_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int POS_W      = 14;
    localparam int TNO_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int ADDR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Defaults and sizes
    localparam int DEF_PASS_DEPTH = 16384;
    localparam int TABLE_COUNT    = 16;
    localparam int TABLE_ENTRIES  = 256;
    localparam int TAB_DEPTH      = TABLE_COUNT * TABLE_ENTRIES;
    localparam int QUEUE_DEPTH    = 4;
    localparam int OUT_DEPTH      = 8;

    // Generator shift and rotate amounts
    localparam int ROT_A   = 55;
    localparam int SHIFT_B = 14;
    localparam int ROT_C   = 36;

    // Fixed-point shift for the start position reduction
    localparam int RECIP_SHIFT = 28;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PROCESS    = 2'd0;
    localparam logic [OP_W-1:0] OP_PASS_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_TAB_WRITE  = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTART    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_WORD0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_WORD1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCRAMBLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERTED    = 3'd5;

    // Configuration write
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

    // Classified item handed from front to back
    typedef struct packed {
        logic [OP_W-1:0]   kind;
        logic              pass_ok;
        logic [ADDR_W-1:0] addr;
        logic [TNO_W-1:0]  tno;
        logic [BYTE_W-1:0] val;
        logic [BYTE_W-1:0] rnd;
    } t_item;

endpackage

FILE: hdl/plsc_ram.sv
// Generic single write port RAM with registered read
module plsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/plsc_queue.sv
// Small register FIFO used between stages and at the result side
module plsc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: hdl/plsc_front.sv
// Front end: accepts items, steps the generator and classifies work for the back end
`include "prng_substitution_stream_cipher_top_assert.svh"
module plsc_front #(
    parameter int PASS_DEPTH = plsc_pkg::DEF_PASS_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [plsc_pkg::OP_W-1:0]      i_operation,
    input  logic [plsc_pkg::POS_W-1:0]     i_position,
    input  logic [plsc_pkg::TNO_W-1:0]     i_table_number,
    input  logic [plsc_pkg::BYTE_W-1:0]    i_byte_value,
    input  plsc_pkg::t_cfg                 i_cfg,
    input  logic                           i_clearing,
    input  logic                           i_q_full,
    output logic                           o_full,
    output logic                           o_item_push,
    output plsc_pkg::t_item                o_item
);

    import plsc_pkg::*;

    localparam int PW    = $clog2(PASS_DEPTH);
    localparam int RECIP = (1 << RECIP_SHIFT) / PASS_DEPTH;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PRW   = POS_W + RW;
    localparam int MUL_W = POS_W + RECIP_SHIFT;
    localparam int DW    = ((POS_W > PW) ? POS_W : PW) + 2;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int r);
        rotl = (v << r) | (v >> (WORD_W - r));
    endfunction

    logic [WORD_W-1:0] r_start0, r_start1;
    logic [PW-1:0]     r_start_pos;
    logic [POS_W-1:0]  r_red_x;
    logic [MUL_W-1:0]  r_red_prod;
    logic [DW-1:0]     r_red_qd;
    logic [2:0]        r_red_v;
    logic [WORD_W-1:0] r_w0, n_w0;
    logic [WORD_W-1:0] r_w1, n_w1;
    logic [PW-1:0]     r_pass_pos, n_pass_pos;

    logic              accept;
    logic [BYTE_W-1:0] rnd;
    logic [WORD_W-1:0] b_x, w0_adv, w1_adv;
    logic [PW-1:0]     pos_inc;
    logic [RW-1:0]     recip_c;
    logic [PRW-1:0]    prod_c;
    logic [POS_W-1:0]  red_q;
    logic [DW-1:0]     red_rem;

    assign o_full = i_q_full || i_clearing || (r_red_v != '0);
    assign accept = i_push && !o_full;

    // Generator step: low byte of the sum, then the xoroshiro update
    assign rnd    = r_w0[BYTE_W-1:0] + r_w1[BYTE_W-1:0];
    assign b_x    = r_w0 ^ r_w1;
    assign w0_adv = rotl(r_w0, ROT_A) ^ b_x ^ (b_x << SHIFT_B);
    assign w1_adv = rotl(b_x, ROT_C);
    assign pos_inc = (r_pass_pos == PW'(PASS_DEPTH - 1)) ? '0 : r_pass_pos + PW'(1);

    // Start position modulo depth: reciprocal multiply, back-multiply, one correction
    assign recip_c = RW'(RECIP);
    assign prod_c  = PRW'(r_red_x) * PRW'(recip_c);
    assign red_q   = r_red_prod[MUL_W-1 -: POS_W];
    assign red_rem = DW'(r_red_x) - r_red_qd;

    // Classified item for the back end
    always_comb begin
        o_item_push    = accept && (i_operation != OP_RESTART);
        o_item.kind    = i_operation;
        o_item.pass_ok = (int'(i_position) < PASS_DEPTH);
        o_item.addr    = (i_operation == OP_PROCESS) ? ADDR_W'(r_pass_pos)
                                                     : ADDR_W'(i_position);
        o_item.tno     = i_table_number;
        o_item.val     = i_byte_value;
        o_item.rnd     = rnd;
    end

    // Generator and passphrase position next state
    always_comb begin
        n_w0       = r_w0;
        n_w1       = r_w1;
        n_pass_pos = r_pass_pos;
        if (accept) begin
            unique case (i_operation)
                OP_PROCESS: begin
                    n_w0       = w0_adv;
                    n_w1       = w1_adv;
                    n_pass_pos = pos_inc;
                end
                OP_RESTART: begin
                    n_w0       = r_start0;
                    n_w1       = r_start1;
                    n_pass_pos = r_start_pos;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0       <= '0;
            r_w1       <= '0;
            r_pass_pos <= '0;
        end else begin
            r_w0       <= n_w0;
            r_w1       <= n_w1;
            r_pass_pos <= n_pass_pos;
        end
    end

    // Start registers and the reduction pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start0    <= '0;
            r_start1    <= '0;
            r_start_pos <= '0;
            r_red_x     <= '0;
            r_red_v     <= '0;
        end else begin
            r_red_v <= {r_red_v[1:0],
                        i_cfg.we && (i_cfg.index == CFG_START_POS)};
            if (i_cfg.we) begin
                unique case (i_cfg.index)
                    CFG_START_WORD0: r_start0 <= i_cfg.data;
                    CFG_START_WORD1: r_start1 <= i_cfg.data;
                    CFG_START_POS:   r_red_x  <= i_cfg.data[POS_W-1:0];
                    default: ;
                endcase
            end
            if (r_red_v[2]) begin
                r_start_pos <= (red_rem >= DW'(PASS_DEPTH))
                             ? PW'(red_rem - DW'(PASS_DEPTH)) : PW'(red_rem);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_red_prod <= MUL_W'(prod_c);
        r_red_qd   <= DW'(red_q) * DW'(PASS_DEPTH);
    end

    `PLSC_ASSERT_NEXT(a_restart_load, i_clk, i_rst_n, accept && (i_operation == OP_RESTART) && !i_cfg.we, (r_w0 == r_start0) && (r_w1 == r_start1) && (r_pass_pos == r_start_pos), "restart did not load the start state")
    `PLSC_ASSERT_IMPLIES(a_no_accept_busy, i_clk, i_rst_n, r_red_v != 3'b000, !o_item_push, "item taken while start position is being reduced")

endmodule

FILE: hdl/plsc_back.sv
// Back end: passphrase and table memories, key byte, substitution and result queue
`include "prng_substitution_stream_cipher_top_assert.svh"
module plsc_back #(
    parameter int PASS_DEPTH = plsc_pkg::DEF_PASS_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  plsc_pkg::t_cfg              i_cfg,
    input  logic                        i_q_empty,
    input  plsc_pkg::t_item             i_q_item,
    output logic                        o_q_pop,
    output logic                        o_clearing,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [plsc_pkg::BYTE_W-1:0] o_data_out
);

    import plsc_pkg::*;

    localparam int PW     = $clog2(PASS_DEPTH);
    localparam int PCW    = $clog2(OUT_DEPTH + 1);
    localparam int TAB_AW = $clog2(TAB_DEPTH);

    // Modes
    logic r_decrypt, r_scramble, r_inverted;

    // Passphrase clearing sweep
    logic          r_clearing;
    logic [PW-1:0] r_clr_addr;

    // Result credit
    logic [PCW-1:0] r_pending, n_pending;
    logic           pend_inc, pend_dec;

    // Pipeline stages
    logic              r_s1_vld;
    t_item             r_s1;
    logic              r_s2_vld;
    logic [BYTE_W-1:0] r_s2_val, r_s2_rnd;
    logic              r_s3_vld;
    logic [BYTE_W-1:0] r_s3_k, r_s3_plain;

    logic              head_proc, pre_xor;
    logic              pass_we;
    logic [PW-1:0]     pass_waddr;
    logic [BYTE_W-1:0] pass_wdata, pass_rdata;
    logic              tab_we;
    logic [TAB_AW-1:0] fwd_waddr, inv_waddr, tab_raddr;
    logic [BYTE_W-1:0] fwd_rdata, inv_rdata, tab_rd;
    logic [BYTE_W-1:0] key, tab_idx, result;
    logic              out_full;

    assign o_clearing = r_clearing;
    assign head_proc  = (i_q_item.kind == OP_PROCESS);
    assign o_q_pop    = !i_q_empty && !r_clearing
                     && (!head_proc || (r_pending < PCW'(OUT_DEPTH)));
    assign pend_inc   = o_q_pop && head_proc;
    assign pend_dec   = i_pop && !o_empty;
    assign pre_xor    = r_decrypt ^ r_inverted;

    // Credit count: results in flight plus results queued
    always_comb begin
        case ({pend_inc, pend_dec})
            2'b10:   n_pending = r_pending + PCW'(1);
            2'b01:   n_pending = r_pending - PCW'(1);
            default: n_pending = r_pending;
        endcase
    end

    // Stage 1: memory writes and passphrase read
    always_comb begin
        if (r_clearing) begin
            pass_we    = 1'b1;
            pass_waddr = r_clr_addr;
            pass_wdata = '0;
        end else begin
            pass_we    = r_s1_vld && (r_s1.kind == OP_PASS_WRITE) && r_s1.pass_ok;
            pass_waddr = PW'(r_s1.addr);
            pass_wdata = r_s1.val;
        end
        tab_we    = r_s1_vld && (r_s1.kind == OP_TAB_WRITE);
        fwd_waddr = {r_s1.tno, r_s1.addr[BYTE_W-1:0]};
        inv_waddr = {r_s1.tno, r_s1.val};
    end

    // Stage 2: key byte and table address
    assign key       = r_s2_rnd ^ pass_rdata;
    assign tab_idx   = pre_xor ? (r_s2_val ^ key) : r_s2_val;
    assign tab_raddr = {key[TNO_W-1:0], tab_idx};

    // Stage 3: substitution result
    always_comb begin
        tab_rd = r_decrypt ? inv_rdata : fwd_rdata;
        if (!r_scramble) begin
            result = r_s3_plain;
        end else if (pre_xor) begin
            result = tab_rd;
        end else begin
            result = tab_rd ^ r_s3_k;
        end
    end

    plsc_ram #(.WIDTH(BYTE_W), .DEPTH(PASS_DEPTH)) u_pass_ram (
        .i_clk   (i_clk),
        .i_we    (pass_we),
        .i_waddr (pass_waddr),
        .i_wdata (pass_wdata),
        .i_raddr (PW'(r_s1.addr)),
        .o_rdata (pass_rdata)
    );

    plsc_ram #(.WIDTH(BYTE_W), .DEPTH(TAB_DEPTH)) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (fwd_waddr),
        .i_wdata (r_s1.val),
        .i_raddr (tab_raddr),
        .o_rdata (fwd_rdata)
    );

    plsc_ram #(.WIDTH(BYTE_W), .DEPTH(TAB_DEPTH)) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (inv_waddr),
        .i_wdata (r_s1.addr[BYTE_W-1:0]),
        .i_raddr (tab_raddr),
        .o_rdata (inv_rdata)
    );

    plsc_queue #(.WIDTH(BYTE_W), .DEPTH(OUT_DEPTH)) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_vld),
        .i_data  (result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_data_out),
        .o_empty (o_empty)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt  <= 1'b0;
            r_scramble <= 1'b1;
            r_inverted <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_pending  <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.index)
                    CFG_DECRYPT:  r_decrypt  <= i_cfg.data[0];
                    CFG_SCRAMBLE: r_scramble <= i_cfg.data[0];
                    CFG_INVERTED: r_inverted <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + PW'(1);
                if (r_clr_addr == PW'(PASS_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_pending <= n_pending;
            r_s1_vld  <= o_q_pop;
            r_s2_vld  <= r_s1_vld && (r_s1.kind == OP_PROCESS);
            r_s3_vld  <= r_s2_vld;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        r_s1       <= i_q_item;
        r_s2_val   <= r_s1.val;
        r_s2_rnd   <= r_s1.rnd;
        r_s3_k     <= key;
        r_s3_plain <= r_s2_val ^ key;
    end

    `PLSC_ASSERT_HOLDS(a_pending_bound, i_clk, i_rst_n, r_pending <= PCW'(OUT_DEPTH), "result credit count overran the queue depth")
    `PLSC_ASSERT_IMPLIES(a_out_room, i_clk, i_rst_n, r_s3_vld, !out_full, "result produced with no room in the result queue")
    `PLSC_ASSERT_IMPLIES(a_clear_quiet, i_clk, i_rst_n, r_clearing, i_q_empty, "work queued while the passphrase store is being cleared")

endmodule

FILE: hdl/prng_substitution_stream_cipher_top.sv
// Top level of the generator-keyed byte substitution stream cipher
//
//   Channel   Handshake               Payload
//   input     push / full             i_operation, i_position, i_table_number, i_byte_value
//   result    pop / empty             o_data_out
//   config    i_cfg_we (no wait)      i_cfg_index, i_cfg_data
//
// One item is taken per cycle while full is low; the front end steps the generator as each process item is taken.
// A process byte passes the work queue, back-end stages s1 to s3 and the result queue.
// After reset the passphrase store is swept to zero at every address, full held high.
// A start_position write holds full high while it is reduced modulo depth.
// Up to eight results may be outstanding; beyond that, process items wait in the queue.
module prng_substitution_stream_cipher_top #(
    parameter int PASS_DEPTH = plsc_pkg::DEF_PASS_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [plsc_pkg::OP_W-1:0]       i_operation,
    input  logic [plsc_pkg::POS_W-1:0]      i_position,
    input  logic [plsc_pkg::TNO_W-1:0]      i_table_number,
    input  logic [plsc_pkg::BYTE_W-1:0]     i_byte_value,
    output logic                            empty,
    input  logic                            pop,
    output logic [plsc_pkg::BYTE_W-1:0]     o_data_out,
    input  logic                            i_cfg_we,
    input  logic [plsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [plsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import plsc_pkg::*;

    localparam int ITEM_W = $bits(t_item);

    t_cfg              cfg;
    t_item             front_item, back_item;
    logic [ITEM_W-1:0] q_rdata;
    logic              item_push, q_full, q_empty, q_pop, clearing;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;
    assign back_item = t_item'(q_rdata);

    plsc_front #(.PASS_DEPTH(PASS_DEPTH)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_operation    (i_operation),
        .i_position     (i_position),
        .i_table_number (i_table_number),
        .i_byte_value   (i_byte_value),
        .i_cfg          (cfg),
        .i_clearing     (clearing),
        .i_q_full       (q_full),
        .o_full         (full),
        .o_item_push    (item_push),
        .o_item         (front_item)
    );

    // Work queue between front and back
    plsc_queue #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_work_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (item_push),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    plsc_back #(.PASS_DEPTH(PASS_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_empty  (q_empty),
        .i_q_item   (back_item),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_data_out (o_data_out)
    );

endmodule

FILE: sim/prng_substitution_stream_cipher_top_test.sv
// Self-checking testbench for the generator-keyed byte substitution stream cipher
module prng_substitution_stream_cipher_top_test import plsc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PASS_DEPTH      = DEF_PASS_DEPTH;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int LOAD_PER_TABLE  = 16;
    localparam int SETTLE_CYCLES   = 20;
    localparam int STALL_LIMIT     = 4 * DEF_PASS_DEPTH;
    localparam int MAX_PRINTED     = 30;

    // Register indexes beyond the defined set; writes to them must do nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [TNO_W-1:0]  tno;
        logic [BYTE_W-1:0] val;
    } cipher_item_t;

    // Ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    logic [OP_W-1:0]       in_op     = OP_PROCESS;
    logic [POS_W-1:0]      in_pos    = '0;
    logic [TNO_W-1:0]      in_table  = '0;
    logic [BYTE_W-1:0]     in_byte   = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Cipher state as predicted
    logic [WORD_W-1:0] gen_s0 = '0;
    logic [WORD_W-1:0] gen_s1 = '0;
    int unsigned       phrase_ptr = 0;
    bit [BYTE_W-1:0]   phrase_store [PASS_DEPTH];
    bit [BYTE_W-1:0]   sbox_fwd [TABLE_COUNT][TABLE_ENTRIES];
    bit [BYTE_W-1:0]   sbox_inv [TABLE_COUNT][TABLE_ENTRIES];

    // Table entries written so far
    bit                fwd_set [TABLE_COUNT][TABLE_ENTRIES];
    bit                inv_set [TABLE_COUNT][TABLE_ENTRIES];

    // Register copies, at their reset values
    logic [WORD_W-1:0] start_s0    = '0;
    logic [WORD_W-1:0] start_s1    = '0;
    logic [POS_W-1:0]  start_ptr   = '0;
    logic              decrypt_on  = 1'b0;
    logic              scramble_on = 1'b1;
    logic              inverted_on = 1'b0;

    // Stimulus and expectation stores
    cipher_item_t      pending_items [$];
    cipher_item_t      on_port;
    logic [BYTE_W-1:0] cipher_bytes_due [$];
    logic [BYTE_W-1:0] due_byte;
    int                items_outstanding = 0;
    int                sender_idle_pct   = 0;
    int                receiver_idle_pct = 0;
    int                mismatch_count    = 0;
    int                stalled_cycles    = 0;

    prng_substitution_stream_cipher_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (in_op),
        .i_position     (in_pos),
        .i_table_number (in_table),
        .i_byte_value   (in_byte),
        .empty          (empty),
        .pop            (pop),
        .o_data_out     (out_byte),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t ns: %s: got %02h, want %02h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Advance the predicted cipher state by one accepted item
    function automatic void apply_item(cipher_item_t it);
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] mixed;
        logic [BYTE_W-1:0] key;
        logic [BYTE_W-1:0] res;
        logic [TNO_W-1:0]  tsel;
        case (it.op)
            OP_PASS_WRITE: begin
                if (it.pos < PASS_DEPTH) phrase_store[it.pos] = it.val;
            end
            OP_TAB_WRITE: begin
                // only the low byte of position indexes the entry
                sbox_fwd[it.tno][it.pos[7:0]] = it.val;
                sbox_inv[it.tno][it.val]      = it.pos[7:0];
                fwd_set[it.tno][it.pos[7:0]]  = 1'b1;
                inv_set[it.tno][it.val]       = 1'b1;
            end
            OP_RESTART: begin
                gen_s0     = start_s0;
                gen_s1     = start_s1;
                phrase_ptr = start_ptr % PASS_DEPTH;
            end
            OP_PROCESS: begin
                // xoroshiro128+ step: output is the sum taken before the update
                sum    = gen_s0 + gen_s1;
                mixed  = gen_s1 ^ gen_s0;
                gen_s0 = ((gen_s0 << ROT_A) | (gen_s0 >> (WORD_W - ROT_A)))
                         ^ mixed ^ (mixed << SHIFT_B);
                gen_s1 = (mixed << ROT_C) | (mixed >> (WORD_W - ROT_C));
                key    = sum[BYTE_W-1:0] ^ phrase_store[phrase_ptr];
                phrase_ptr = (phrase_ptr == PASS_DEPTH - 1) ? 0 : phrase_ptr + 1;
                tsel   = key[TNO_W-1:0];
                if (!scramble_on) begin
                    res = it.val ^ key;
                end else if (!decrypt_on) begin
                    res = inverted_on ? sbox_fwd[tsel][it.val ^ key]
                                      : sbox_fwd[tsel][it.val] ^ key;
                end else begin
                    res = inverted_on ? sbox_inv[tsel][it.val] ^ key
                                      : sbox_inv[tsel][it.val ^ key];
                end
                cipher_bytes_due.push_back(res);
            end
        endcase
    endfunction

    // Move a scrambled data byte onto a table entry that has been written
    function automatic logic [BYTE_W-1:0] steer_byte(logic [BYTE_W-1:0] val);
        logic [WORD_W-1:0] sum;
        logic [BYTE_W-1:0] key;
        logic [BYTE_W-1:0] idx;
        logic [TNO_W-1:0]  tsel;
        logic              pre;
        sum  = gen_s0 + gen_s1;
        key  = sum[BYTE_W-1:0] ^ phrase_store[phrase_ptr];
        tsel = key[TNO_W-1:0];
        pre  = decrypt_on ^ inverted_on;
        idx  = pre ? (val ^ key) : val;
        for (int n = 0; n < TABLE_ENTRIES; n++) begin
            if (decrypt_on ? inv_set[tsel][idx] : fwd_set[tsel][idx]) break;
            idx = idx + 8'd1;
        end
        return pre ? (idx ^ key) : idx;
    endfunction

    // Input side: one transfer per cycle at most, gaps at random
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                apply_item(on_port);
                items_outstanding--;
            end
            if (!push || !full) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    on_port  = pending_items.pop_front();
                    // every earlier item is already in the prediction here
                    if (on_port.op == OP_PROCESS && scramble_on) begin
                        on_port.val = steer_byte(on_port.val);
                    end
                    in_op    <= on_port.op;
                    in_pos   <= on_port.pos;
                    in_table <= on_port.tno;
                    in_byte  <= on_port.val;
                    push     <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result side: compare each transfer with the oldest byte due
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (cipher_bytes_due.size() == 0) begin
                    report_mismatch("unexpected result", out_byte, 8'h00);
                end else begin
                    due_byte = cipher_bytes_due.pop_front();
                    if (out_byte !== due_byte) report_mismatch("data_out", out_byte, due_byte);
                end
            end
            pop <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    task automatic queue_item(cipher_item_t it);
        pending_items.push_back(it);
        items_outstanding++;
    endtask

    // Block is idle once all items are in, all bytes out and the pipeline has emptied
    task automatic wait_drained();
        while (items_outstanding != 0 || cipher_bytes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_START_WORD0: start_s0    = data;
            CFG_START_WORD1: start_s1    = data;
            CFG_START_POS:   start_ptr   = data[POS_W-1:0];
            CFG_DECRYPT:     decrypt_on  = data[0];
            CFG_SCRAMBLE:    scramble_on = data[0];
            CFG_INVERTED:    inverted_on = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Register value with random bits above the field, which must be ignored
    function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CFG_DATA_W-1:0] field, int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = (64'd1 << width) - 1;
        return ({$urandom(), $urandom()} & ~keep) | (field & keep);
    endfunction

    // Seed every table with entries from a random permutation; data bytes are
    // then steered onto entries that hold a value
    task automatic queue_table_load();
        logic [BYTE_W-1:0] perm [TABLE_ENTRIES];
        logic [BYTE_W-1:0] swap;
        int                j;
        for (int t = 0; t < TABLE_COUNT; t++) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) perm[i] = BYTE_W'(i);
            for (int i = TABLE_ENTRIES - 1; i > 0; i--) begin
                j       = $urandom_range(i);
                swap    = perm[i];
                perm[i] = perm[j];
                perm[j] = swap;
            end
            for (int i = 0; i < LOAD_PER_TABLE; i++) begin
                queue_item(cipher_item_t'{OP_TAB_WRITE,
                    {6'($urandom_range(63)), 8'(i)}, 4'(t), perm[i]});
            end
        end
    endtask

    // Mostly data bytes; passphrase writes cluster near the restart position
    task automatic queue_random_items(int count);
        cipher_item_t it;
        int           pick;
        repeat (count) begin
            pick   = $urandom_range(99);
            it.pos = POS_W'($urandom_range(PASS_DEPTH - 1));
            it.tno = TNO_W'($urandom_range(TABLE_COUNT - 1));
            it.val = BYTE_W'($urandom_range(255));
            if (pick < 70) begin
                it.op = OP_PROCESS;
            end else if (pick < 82) begin
                it.op = OP_PASS_WRITE;
                if ($urandom_range(9) < 6) begin
                    it.pos = POS_W'((start_ptr + $urandom_range(63)) % PASS_DEPTH);
                end
            end else if (pick < 95) begin
                it.op = OP_TAB_WRITE;
            end else begin
                it.op = OP_RESTART;
            end
            queue_item(it);
        end
    endtask

    // One setting of all registers, a restart, then random traffic
    task automatic run_phase(logic dec, logic scr, logic inv,
                             logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                             logic [POS_W-1:0] p);
        write_register(CFG_START_WORD0, w0);
        write_register(CFG_START_WORD1, w1);
        write_register(CFG_START_POS, with_noise(CFG_DATA_W'(p), POS_W));
        write_register(CFG_DECRYPT, with_noise(CFG_DATA_W'(dec), 1));
        write_register(CFG_SCRAMBLE, with_noise(CFG_DATA_W'(scr), 1));
        write_register(CFG_INVERTED, with_noise(CFG_DATA_W'(inv), 1));
        queue_item(cipher_item_t'{OP_RESTART, 14'h0000, 4'h0, 8'h00});
        queue_random_items(ITEMS_PER_PHASE);
        wait_drained();
    endtask

    initial begin
        sender_idle_pct   = 33;
        receiver_idle_pct = 76;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_table_load();

        // zero generator and blank passphrase: key byte is zero
        queue_item(cipher_item_t'{OP_PROCESS, 14'h0000, 4'h0, 8'h00});
        queue_item(cipher_item_t'{OP_PROCESS, 14'h3FFF, 4'hF, 8'hFF});
        // passphrase slots at both ends
        queue_item(cipher_item_t'{OP_PASS_WRITE, 14'h0000, 4'h0, 8'hFF});
        queue_item(cipher_item_t'{OP_PASS_WRITE, 14'h3FFF, 4'hF, 8'hA5});
        queue_item(cipher_item_t'{OP_PASS_WRITE, 14'h0002, 4'h5, 8'h5A});
        queue_item(cipher_item_t'{OP_RESTART, 14'h3FFF, 4'hF, 8'hFF});
        queue_item(cipher_item_t'{OP_PROCESS, 14'h2AAA, 4'hA, 8'h00});
        queue_item(cipher_item_t'{OP_PROCESS, 14'h1555, 4'h5, 8'hFF});
        queue_item(cipher_item_t'{OP_PROCESS, 14'h0000, 4'h0, 8'h3C});
        // rewrite forward entries; the old inverse entries stay behind
        queue_item(cipher_item_t'{OP_TAB_WRITE, 14'h3F00, 4'hF, 8'h77});
        queue_item(cipher_item_t'{OP_TAB_WRITE, 14'h00FF, 4'h0, 8'h00});
        queue_item(cipher_item_t'{OP_TAB_WRITE, 14'h3FFF, 4'hF, 8'hFF});
        queue_item(cipher_item_t'{OP_RESTART, 14'h0000, 4'h0, 8'h00});
        queue_item(cipher_item_t'{OP_PROCESS, 14'h0000, 4'h0, 8'h00});
        queue_item(cipher_item_t'{OP_PROCESS, 14'h3FFF, 4'hF, 8'hFF});
        queue_item(cipher_item_t'{OP_PROCESS, 14'h0000, 4'h0, 8'hFF});
        queue_item(cipher_item_t'{OP_PROCESS, 14'h0000, 4'h0, 8'h80});
        wait_drained();

        run_phase(1'b0, 1'b1, 1'b0, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  POS_W'($urandom_range(PASS_DEPTH - 1)));
        // all-ones start words and the last slot, so the position wraps
        run_phase(1'b0, 1'b1, 1'b1, '1, '1, 14'h3FFF);

        sender_idle_pct   = 76;
        receiver_idle_pct = 33;
        run_phase(1'b1, 1'b1, 1'b0, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  POS_W'($urandom_range(PASS_DEPTH - 1)));
        // generator stuck at zero: key comes from the passphrase alone
        run_phase(1'b1, 1'b1, 1'b1, '0, '0, 14'h0000);
        run_phase(1'b0, 1'b0, 1'b0, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  POS_W'($urandom_range(PASS_DEPTH - 1)));

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_phase(1'b1, 1'b0, 1'b1, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  POS_W'($urandom_range(PASS_DEPTH - 1)));
        write_register(CFG_UNUSED_LO, {$urandom(), $urandom()});
        write_register(CFG_UNUSED_HI, '1);
        run_phase(1'b0, 1'b1, 1'b0, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  POS_W'($urandom_range(PASS_DEPTH - 1)));
        run_phase(1'b1, 1'b1, 1'b1, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                  POS_W'($urandom_range(PASS_DEPTH - 1)));

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
